FILE: hw/rtl/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg: shared types and constants for the ride auto pause/resume block
// Holds the request and result payload types, the configuration bundle,
// the ride mode codes, the command codes and the register indexes.
// ----------------------------------------------------------------------------
package rap_pkg;

    // Ride mode codes.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_PAUSED = 2'd2;

    // Command codes. The unused code behaves as a plain sample.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Configuration port geometry and register indexes.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RESUME_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESUME_HOLD_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_HOLD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD_MS = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_RESUME_SPEED   = 16'd400;
    localparam logic [15:0] RST_PAUSE_SPEED    = 16'd150;
    localparam logic [15:0] RST_RESUME_HOLD_MS = 16'd3000;
    localparam logic [15:0] RST_PAUSE_HOLD_MS  = 16'd5000;
    localparam logic [15:0] RST_TICK_PERIOD_MS = 16'd1000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [15:0] speed_centi;
        logic        speed_ok;
        logic        auto_allowed;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  ride_mode;
        logic [31:0] ride_seconds_out;
        logic        did_resume;
        logic        did_pause;
    } out_item_t;

    typedef struct packed {
        logic [15:0] resume_speed;
        logic [15:0] pause_speed;
        logic [15:0] resume_hold_ms;
        logic [15:0] pause_hold_ms;
        logic [15:0] tick_period_ms;
    } cfg_t;

endpackage

FILE: hw/rtl/rap_cfg_regs.sv
// ----------------------------------------------------------------------------
// rap_cfg_regs: configuration registers
// Five 16-bit write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module rap_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rap_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    output rap_pkg::cfg_t                     cfg
);

    rap_pkg::cfg_t cfg_reg;
    rap_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                rap_pkg::REG_RESUME_SPEED:   cfg_next.resume_speed   = cfg_wr_data;
                rap_pkg::REG_PAUSE_SPEED:    cfg_next.pause_speed    = cfg_wr_data;
                rap_pkg::REG_RESUME_HOLD_MS: cfg_next.resume_hold_ms = cfg_wr_data;
                rap_pkg::REG_PAUSE_HOLD_MS:  cfg_next.pause_hold_ms  = cfg_wr_data;
                rap_pkg::REG_TICK_PERIOD_MS: cfg_next.tick_period_ms = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.resume_speed   <= rap_pkg::RST_RESUME_SPEED;
            cfg_reg.pause_speed    <= rap_pkg::RST_PAUSE_SPEED;
            cfg_reg.resume_hold_ms <= rap_pkg::RST_RESUME_HOLD_MS;
            cfg_reg.pause_hold_ms  <= rap_pkg::RST_PAUSE_HOLD_MS;
            cfg_reg.tick_period_ms <= rap_pkg::RST_TICK_PERIOD_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/rap_core.sv
// ----------------------------------------------------------------------------
// rap_core: ride state and per-sample update
// Holds the ride mode, dwell timers, tick stamp and second count, and
// computes the next state and the result for one sample combinationally.
// ----------------------------------------------------------------------------
module rap_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_go,
    input  rap_pkg::in_item_t    item,
    input  rap_pkg::cfg_t        cfg,
    output rap_pkg::out_item_t   result
);

    logic [1:0]  mode_reg,         mode_next;
    logic [31:0] fast_since_reg,   fast_since_next;
    logic        fast_armed_reg,   fast_armed_next;
    logic [31:0] slow_since_reg,   slow_since_next;
    logic        slow_armed_reg,   slow_armed_next;
    logic [31:0] last_tick_reg,    last_tick_next;
    logic [31:0] ride_seconds_reg, ride_seconds_next;

    logic [31:0] fast_elapsed;
    logic [31:0] slow_elapsed;
    logic [31:0] tick_elapsed;
    logic        resumed;
    logic        paused;
    logic        gate_open;

    // Elapsed times are taken modulo 2^32 against the stored stamps.
    assign fast_elapsed = item.now_ms - fast_since_reg;
    assign slow_elapsed = item.now_ms - slow_since_reg;

    always_comb begin
        mode_next         = mode_reg;
        fast_since_next   = fast_since_reg;
        fast_armed_next   = fast_armed_reg;
        slow_since_next   = slow_since_reg;
        slow_armed_next   = slow_armed_reg;
        last_tick_next    = last_tick_reg;
        ride_seconds_next = ride_seconds_reg;
        resumed           = 1'b0;
        paused            = 1'b0;

        // Command first.
        case (item.cmd)
            rap_pkg::CMD_START: begin
                mode_next         = rap_pkg::MODE_ACTIVE;
                ride_seconds_next = 32'd0;
                fast_armed_next   = 1'b0;
                slow_armed_next   = 1'b0;
                last_tick_next    = item.now_ms;
            end
            rap_pkg::CMD_STOP: begin
                mode_next       = rap_pkg::MODE_IDLE;
                fast_armed_next = 1'b0;
                slow_armed_next = 1'b0;
            end
            default: ;
        endcase

        // Dwell logic sees the mode after the command.
        gate_open = item.auto_allowed && item.speed_ok && (mode_next != rap_pkg::MODE_IDLE);
        if (!gate_open) begin
            fast_armed_next = 1'b0;
            slow_armed_next = 1'b0;
        end else if (item.speed_centi >= cfg.resume_speed) begin
            slow_armed_next = 1'b0;
            if (!fast_armed_next) begin
                fast_armed_next = 1'b1;
                fast_since_next = item.now_ms;
            end else if (fast_elapsed >= {16'd0, cfg.resume_hold_ms}) begin
                if (mode_next == rap_pkg::MODE_PAUSED) begin
                    mode_next = rap_pkg::MODE_ACTIVE;
                    resumed   = 1'b1;
                end
            end
        end else if (item.speed_centi < cfg.pause_speed) begin
            fast_armed_next = 1'b0;
            if (mode_next == rap_pkg::MODE_ACTIVE) begin
                if (!slow_armed_next) begin
                    slow_armed_next = 1'b1;
                    slow_since_next = item.now_ms;
                end else if (slow_elapsed >= {16'd0, cfg.pause_hold_ms}) begin
                    mode_next = rap_pkg::MODE_PAUSED;
                    paused    = 1'b1;
                end
            end
        end else begin
            fast_armed_next = 1'b0;
            slow_armed_next = 1'b0;
        end

        // Period tick, measured from the stamp as left by the command.
        tick_elapsed = item.now_ms - last_tick_next;
        if (tick_elapsed >= {16'd0, cfg.tick_period_ms}) begin
            last_tick_next = item.now_ms;
            if (mode_next == rap_pkg::MODE_ACTIVE) begin
                ride_seconds_next = ride_seconds_next + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= rap_pkg::MODE_IDLE;
            fast_since_reg   <= 32'd0;
            fast_armed_reg   <= 1'b0;
            slow_since_reg   <= 32'd0;
            slow_armed_reg   <= 1'b0;
            last_tick_reg    <= 32'd0;
            ride_seconds_reg <= 32'd0;
        end else if (step_go) begin
            mode_reg         <= mode_next;
            fast_since_reg   <= fast_since_next;
            fast_armed_reg   <= fast_armed_next;
            slow_since_reg   <= slow_since_next;
            slow_armed_reg   <= slow_armed_next;
            last_tick_reg    <= last_tick_next;
            ride_seconds_reg <= ride_seconds_next;
        end
    end

    assign result.ride_mode        = mode_next;
    assign result.ride_seconds_out = ride_seconds_next;
    assign result.did_resume       = resumed;
    assign result.did_pause        = paused;

    // A stop request always leaves the ride idle.
    a_stop_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go && (item.cmd == rap_pkg::CMD_STOP) |=> mode_reg == rap_pkg::MODE_IDLE)
        else $error("ride not idle after stop request");

    // Ride time only moves when a request is processed.
    a_seconds_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_go |=> $stable(ride_seconds_reg))
        else $error("ride seconds changed without a request");

endmodule

FILE: hw/rtl/ride_auto_pause_resume.sv
// ----------------------------------------------------------------------------
// ride_auto_pause_resume: ride auto pause/resume controller
// Tracks ride mode and active ride time from a stream of speed samples.
// ----------------------------------------------------------------------------
// Each request is one loop sample (command, millisecond timestamp, speed,
// speed-valid and auto-allowed flags) and yields exactly one result with the
// ride mode after the sample, the active ride seconds, and pulses that say
// whether this sample resumed or paused the ride. The block takes one request
// per clock while results are being taken: a request is captured in an input
// register, and once the output register is free or is being emptied the
// ride state is updated in a single pass and the result is written to an
// output register, from which it can be taken. The throughput is set by the
// update of the ride state, which each sample must see fully updated by the
// one before it. The output register holds a finished result while the next
// request is already being taken; backpressure on the result side stalls
// the input side only once both registers are full.
// Configuration registers are written through the plain write port and
// should be changed only while no request is in flight.
// ----------------------------------------------------------------------------
module ride_auto_pause_resume (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  rap_pkg::in_item_t                 s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output rap_pkg::out_item_t                m_data,

    input  logic                              cfg_wr_en,
    input  logic [rap_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rap_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    rap_pkg::cfg_t      cfg;
    rap_pkg::out_item_t step_result;

    logic               in_valid_reg;
    rap_pkg::in_item_t  in_data_reg;
    logic               out_valid_reg;
    rap_pkg::out_item_t out_data_reg;

    logic               step_go;
    logic               s_take;

    // The held sample is processed whenever the output register is free or
    // is being emptied in this same cycle.
    assign step_go = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_go;
    assign s_take  = s_valid && s_ready;

    rap_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    rap_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_go (step_go),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Input register: payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (step_go) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (step_go) begin
            out_data_reg <= step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // A resume pulse always comes with an active ride.
    a_resume_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.did_resume |-> m_data.ride_mode == rap_pkg::MODE_ACTIVE)
        else $error("resume reported without an active ride");

    // A pause pulse always comes with a paused ride.
    a_pause_paused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.did_pause |-> m_data.ride_mode == rap_pkg::MODE_PAUSED)
        else $error("pause reported without a paused ride");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ride auto pause/resume controller
// Drives ride samples through the request channel with random idling on both
// sides, predicts every ride status in the bench itself and compares each
// result with the oldest queued status, field by field.
// ----------------------------------------------------------------------------
module tb;

    // The spare command code; the block treats it as a plain sample.
    localparam logic [1:0] CMD_SPARE = 2'd3;

    localparam int unsigned STALL_LIMIT     = 400;
    localparam int unsigned ITEMS_PER_PHASE = 225;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned DIR_ROWS        = 23;

    // One row of the directed table. When typed is set, want holds the status
    // worked out by hand; otherwise the predictor supplies it.
    typedef struct packed {
        rap_pkg::in_item_t  req;
        logic               typed;
        rap_pkg::out_item_t want;
    } dir_row_t;

    localparam rap_pkg::out_item_t NO_WANT = '0;

    // The directed part runs with the reset configuration: resume at 400,
    // pause below 150, 3000 ms to resume, 5000 ms to pause, 1000 ms per tick.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // Idle after reset: nothing moves, no tick at time zero.
        '{'{rap_pkg::CMD_SAMPLE, 32'd0,         16'd0,    1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_IDLE,   32'd0, 1'b0, 1'b0}},
        // Start at timestamp zero; the resume timer arms at time zero.
        '{'{rap_pkg::CMD_START,  32'd0,         16'd500,  1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_ACTIVE, 32'd0, 1'b0, 1'b0}},
        // First tick one period later; the pause timer arms.
        '{'{rap_pkg::CMD_SAMPLE, 32'd1000,      16'd100,  1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_ACTIVE, 32'd1, 1'b0, 1'b0}},
        // Slow for exactly the pause hold time.
        '{'{rap_pkg::CMD_SAMPLE, 32'd6000,      16'd0,    1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_PAUSED, 32'd1, 1'b0, 1'b1}},
        // Slow while paused leaves the pause timer alone.
        '{'{rap_pkg::CMD_SAMPLE, 32'd7000,      16'd100,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'd7500,      16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_WANT},
        // Exactly at the resume threshold for exactly the resume hold time.
        '{'{rap_pkg::CMD_SAMPLE, 32'd10500,     16'd400,  1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_ACTIVE, 32'd2, 1'b1, 1'b0}},
        // Between the thresholds clears both timers.
        '{'{rap_pkg::CMD_SAMPLE, 32'd10600,     16'd200,  1'b1, 1'b1}, 1'b0, NO_WANT},
        // Invalid speed, then auto control not allowed: the gate is closed.
        '{'{rap_pkg::CMD_SAMPLE, 32'd12000,     16'd0,    1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'd20000,     16'd0,    1'b1, 1'b0}, 1'b0, NO_WANT},
        // The spare command acts as a sample, just below the pause threshold.
        '{'{CMD_SPARE,           32'd20100,     16'd149,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'd25100,     16'd149,  1'b1, 1'b1}, 1'b0, NO_WANT},
        // Stop keeps the second count.
        '{'{rap_pkg::CMD_STOP,   32'd25200,     16'd500,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'hFFFF_FFFF, 16'd500,  1'b1, 1'b1}, 1'b0, NO_WANT},
        // A ride that starts just before the timestamp wraps.
        '{'{rap_pkg::CMD_START,  32'hFFFF_FE00, 16'd500,  1'b1, 1'b1}, 1'b1,
          '{rap_pkg::MODE_ACTIVE, 32'd0, 1'b0, 1'b0}},
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_0300, 16'd500,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_0400, 16'd100,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_1788, 16'd100,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_1800, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_WANT},
        // One millisecond short of the resume hold time, then exactly on it.
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_23B7, 16'd500,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_SAMPLE, 32'h0000_23B8, 16'd500,  1'b1, 1'b1}, 1'b0, NO_WANT},
        '{'{rap_pkg::CMD_STOP,   32'h0000_2400, 16'd0,    1'b1, 1'b1}, 1'b0, NO_WANT},
        // Every field at its top value while idle.
        '{'{CMD_SPARE,           32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1}, 1'b0, NO_WANT}
    };

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    rap_pkg::in_item_t              s_data      = '0;
    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    rap_pkg::out_item_t             m_data;
    logic                           cfg_wr_en   = 1'b0;
    logic [rap_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [rap_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;

    // These travel with each request so the checker knows whether a
    // hand-written status belongs to it.
    logic               req_typed = 1'b0;
    rap_pkg::out_item_t req_want  = '0;

    // Once set, neither side idles any more.
    bit calm = 1'b0;
    // Requests left in a stretch during which the sender does not idle.
    int unsigned quiet_left = 0;

    // Bench copy of the configuration and of the ride state.
    rap_pkg::cfg_t ride_cfg;
    logic [1:0]    mode_q;
    logic [31:0]   fast_since_q;
    logic [31:0]   slow_since_q;
    logic [31:0]   last_tick_q;
    logic [31:0]   seconds_q;
    bit            fast_armed_q;
    bit            slow_armed_q;

    // Running timestamp for shaped samples.
    logic [31:0] stamp_ms;

    rap_pkg::out_item_t pending_status_q [$];
    int unsigned requests_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;

    ride_auto_pause_resume dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Ride status predictor. Order within one sample: the command, then the
    // dwell timers, then the ride-second tick. All elapsed times wrap.
    function automatic rap_pkg::out_item_t advance_ride(rap_pkg::in_item_t req);
        rap_pkg::out_item_t status;
        logic [31:0]        elapsed;
        status = '0;
        case (req.cmd)
            rap_pkg::CMD_START: begin
                mode_q       = rap_pkg::MODE_ACTIVE;
                seconds_q    = '0;
                fast_armed_q = 1'b0;
                slow_armed_q = 1'b0;
                last_tick_q  = req.now_ms;
            end
            rap_pkg::CMD_STOP: begin
                mode_q       = rap_pkg::MODE_IDLE;
                fast_armed_q = 1'b0;
                slow_armed_q = 1'b0;
            end
            default: ;
        endcase

        if (!req.auto_allowed || mode_q == rap_pkg::MODE_IDLE || !req.speed_ok) begin
            fast_armed_q = 1'b0;
            slow_armed_q = 1'b0;
        end else if (req.speed_centi >= ride_cfg.resume_speed) begin
            // The resume test comes first, even when the thresholds overlap.
            slow_armed_q = 1'b0;
            elapsed = req.now_ms - fast_since_q;
            if (!fast_armed_q) begin
                fast_armed_q = 1'b1;
                fast_since_q = req.now_ms;
            end else if (elapsed >= 32'(ride_cfg.resume_hold_ms) &&
                         mode_q == rap_pkg::MODE_PAUSED) begin
                mode_q            = rap_pkg::MODE_ACTIVE;
                status.did_resume = 1'b1;
            end
        end else if (req.speed_centi < ride_cfg.pause_speed) begin
            fast_armed_q = 1'b0;
            elapsed = req.now_ms - slow_since_q;
            if (mode_q == rap_pkg::MODE_ACTIVE) begin
                if (!slow_armed_q) begin
                    slow_armed_q = 1'b1;
                    slow_since_q = req.now_ms;
                end else if (elapsed >= 32'(ride_cfg.pause_hold_ms)) begin
                    mode_q           = rap_pkg::MODE_PAUSED;
                    status.did_pause = 1'b1;
                end
            end
        end else begin
            fast_armed_q = 1'b0;
            slow_armed_q = 1'b0;
        end

        elapsed = req.now_ms - last_tick_q;
        if (elapsed >= 32'(ride_cfg.tick_period_ms)) begin
            last_tick_q = req.now_ms;
            if (mode_q == rap_pkg::MODE_ACTIVE)
                seconds_q = seconds_q + 32'd1;
        end

        status.ride_mode        = mode_q;
        status.ride_seconds_out = seconds_q;
        return status;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Checker. At each edge the request taken at that edge gets its status
    // queued first, then a result taken at the same edge is compared with
    // the oldest queued status. Both sides are sampled before the edge
    // updates land, so the order of processes within the step does not
    // matter.
    always @(posedge aclk) begin : status_check
        rap_pkg::out_item_t predicted;
        rap_pkg::out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = advance_ride(s_data);
                pending_status_q.push_back(req_typed ? req_want : predicted);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_status_q.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request pending, expected none, actual %h",
                             $time, m_data);
                end else begin
                    want = pending_status_q.pop_front();
                    check_field("ride_mode", 32'(want.ride_mode), 32'(m_data.ride_mode));
                    check_field("ride_seconds_out", want.ride_seconds_out,
                                m_data.ride_seconds_out);
                    check_field("did_resume", 32'(want.did_resume), 32'(m_data.did_resume));
                    check_field("did_pause", 32'(want.did_pause), 32'(m_data.did_pause));
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no request and no result taken
    // means the block has hung.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("FAIL ride_auto_pause_resume");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts between ready runs of random length,
    // with an occasional long run that never stalls.
    initial begin : result_sink
        forever begin
            if (!calm && $urandom_range(99, 0) < 30) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(9, 0) == 0)
                repeat ($urandom_range(60, 30)) @(posedge aclk);
            else
                repeat ($urandom_range(12, 1)) @(posedge aclk);
        end
    end

    // Present one request and hold it until taken, then maybe idle for a
    // burst. The next request raises valid in the same step the previous one
    // was taken, so valid is never dropped and raised within one step.
    task automatic send_request(rap_pkg::in_item_t req, logic typed,
                                rap_pkg::out_item_t want);
        s_valid   <= 1'b1;
        s_data    <= req;
        req_typed <= typed;
        req_want  <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        if (quiet_left > 0)
            quiet_left--;
        else if ($urandom_range(49, 0) == 0)
            quiet_left = $urandom_range(40, 20);
        if (!calm && quiet_left == 0 && $urandom_range(99, 0) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge aclk);
        end
    endtask

    // Stop sending and wait until every request has its result back, then
    // let the two-stage pipeline settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != requests_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all five registers on consecutive edges; the write enable stays
    // high across them and drops after the last one.
    task automatic load_config(rap_pkg::cfg_t c);
        logic [rap_pkg::CFG_DATA_W-1:0] vals [5];
        logic [rap_pkg::CFG_IDX_W-1:0]  idxs [5];
        vals = '{c.resume_speed, c.pause_speed, c.resume_hold_ms,
                 c.pause_hold_ms, c.tick_period_ms};
        idxs = '{rap_pkg::REG_RESUME_SPEED, rap_pkg::REG_PAUSE_SPEED,
                 rap_pkg::REG_RESUME_HOLD_MS, rap_pkg::REG_PAUSE_HOLD_MS,
                 rap_pkg::REG_TICK_PERIOD_MS};
        for (int k = 0; k < 5; k++) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= idxs[k];
            cfg_wr_data <= vals[k];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        ride_cfg = c;
    endtask

    // A sample whose speed falls in the chosen band for the current
    // thresholds: 0 fast, 1 slow, 2 between, otherwise anywhere. Time moves
    // in steps scaled to the hold and tick times, so dwells both expire and
    // get cut short.
    function automatic rap_pkg::in_item_t shaped_sample(logic [1:0] cmd, int unsigned kind);
        rap_pkg::in_item_t req;
        int unsigned       span;
        span = ride_cfg.resume_hold_ms;
        if (ride_cfg.pause_hold_ms > span)
            span = ride_cfg.pause_hold_ms;
        if (ride_cfg.tick_period_ms > span)
            span = ride_cfg.tick_period_ms;
        span = span / 3 + 20;
        case ($urandom_range(9, 0))
            0:       ;
            1:       stamp_ms = stamp_ms + span * 4;
            default: stamp_ms = stamp_ms + $urandom_range(span, 0);
        endcase

        req.cmd          = cmd;
        req.now_ms       = stamp_ms;
        req.speed_ok     = ($urandom_range(19, 0) != 0);
        req.auto_allowed = ($urandom_range(19, 0) != 0);
        case (kind)
            0: req.speed_centi = 16'($urandom_range(65535, ride_cfg.resume_speed));
            1: begin
                if (ride_cfg.pause_speed == 0)
                    req.speed_centi = 16'($urandom_range(65535, 0));
                else
                    req.speed_centi = 16'($urandom_range(ride_cfg.pause_speed - 1, 0));
            end
            2: begin
                if (ride_cfg.pause_speed < ride_cfg.resume_speed)
                    req.speed_centi = 16'($urandom_range(ride_cfg.resume_speed - 1,
                                                         ride_cfg.pause_speed));
                else
                    req.speed_centi = 16'($urandom_range(65535, 0));
            end
            default: req.speed_centi = 16'($urandom_range(65535, 0));
        endcase
        return req;
    endfunction

    initial begin : stimulus
        rap_pkg::in_item_t req;
        rap_pkg::cfg_t     phase_cfg;
        int unsigned       n;
        int unsigned       run_len;
        int unsigned       kind;
        bit                held;
        logic [1:0]        cmd;

        // Bench state mirrors the block's reset state.
        ride_cfg = '{rap_pkg::RST_RESUME_SPEED, rap_pkg::RST_PAUSE_SPEED,
                     rap_pkg::RST_RESUME_HOLD_MS, rap_pkg::RST_PAUSE_HOLD_MS,
                     rap_pkg::RST_TICK_PERIOD_MS};
        mode_q       = rap_pkg::MODE_IDLE;
        fast_since_q = '0;
        slow_since_q = '0;
        last_tick_q  = '0;
        seconds_q    = '0;
        fast_armed_q = 1'b0;
        slow_armed_q = 1'b0;
        stamp_ms     = '0;
        held         = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset configuration.
        for (int r = 0; r < DIR_ROWS; r++)
            send_request(DIR_TABLE[r].req, DIR_TABLE[r].typed, DIR_TABLE[r].want);

        // Random part, one configuration per phase. Each change waits for
        // the block to go idle first.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    // Ordinary thresholds around the defaults.
                    phase_cfg.resume_speed   = 16'($urandom_range(900, 200));
                    phase_cfg.pause_speed    =
                        16'($urandom_range(phase_cfg.resume_speed, 0));
                    phase_cfg.resume_hold_ms = 16'($urandom_range(6000, 0));
                    phase_cfg.pause_hold_ms  = 16'($urandom_range(6000, 0));
                    phase_cfg.tick_period_ms = 16'($urandom_range(2500, 1));
                end
                // Bottom extremes: every speed counts as fast, holds expire
                // at once and every sample ticks.
                1: phase_cfg = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0};
                // Top extremes: only the top speed is fast, nothing is slow.
                2: phase_cfg = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                // Pause threshold above the resume threshold.
                3: phase_cfg = '{16'd300, 16'd500, 16'd1000, 16'd1000, 16'd500};
                4: begin
                    phase_cfg.resume_speed   = 16'($urandom_range(65535, 0));
                    phase_cfg.pause_speed    = 16'($urandom_range(65535, 0));
                    phase_cfg.resume_hold_ms = 16'($urandom_range(65535, 0));
                    phase_cfg.pause_hold_ms  = 16'($urandom_range(65535, 0));
                    phase_cfg.tick_period_ms = 16'($urandom_range(65535, 1));
                end
                default: begin
                    // Back to the reset values, and no idling to the end.
                    phase_cfg = '{rap_pkg::RST_RESUME_SPEED, rap_pkg::RST_PAUSE_SPEED,
                                  rap_pkg::RST_RESUME_HOLD_MS, rap_pkg::RST_PAUSE_HOLD_MS,
                                  rap_pkg::RST_TICK_PERIOD_MS};
                    calm = 1'b1;
                end
            endcase
            load_config(phase_cfg);
            // Start each phase close below the wrap of the timestamp.
            stamp_ms = 32'hFFFF_FFFF - $urandom_range(200000, 0);

            n = 0;
            while (n < ITEMS_PER_PHASE) begin
                if (p == 0 && n >= 100 && !held) begin
                    // Hold off once in mid-stream until everything is back.
                    drain_results();
                    held = 1'b1;
                end
                if ($urandom_range(99, 0) < 15) begin
                    // Noise: any command, any time, any flags.
                    req.cmd          = 2'($urandom_range(3, 0));
                    req.now_ms       = $urandom;
                    req.speed_centi  = 16'($urandom_range(65535, 0));
                    req.speed_ok     = 1'($urandom_range(1, 0));
                    req.auto_allowed = 1'($urandom_range(1, 0));
                    stamp_ms = req.now_ms;
                    send_request(req, 1'b0, NO_WANT);
                    n++;
                end else begin
                    // A ride segment: maybe a start, a run of samples in one
                    // speed band, maybe a stop.
                    if ($urandom_range(3, 0) == 0) begin
                        send_request(shaped_sample(rap_pkg::CMD_START, $urandom_range(3, 0)),
                                     1'b0, NO_WANT);
                        n++;
                    end
                    kind    = $urandom_range(3, 0);
                    run_len = $urandom_range(12, 3);
                    repeat (run_len) begin
                        cmd = ($urandom_range(19, 0) == 0) ? CMD_SPARE : rap_pkg::CMD_SAMPLE;
                        send_request(shaped_sample(cmd, kind), 1'b0, NO_WANT);
                        n++;
                    end
                    if ($urandom_range(9, 0) == 0) begin
                        send_request(shaped_sample(rap_pkg::CMD_STOP, $urandom_range(3, 0)),
                                     1'b0, NO_WANT);
                        n++;
                    end
                end
            end
        end

        // Let every result come home, then wait for any stray result before the
        // verdict.
        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_status_q.size() == 0) begin
            $display("PASS ride_auto_pause_resume");
        end else begin
            $display("FAIL ride_auto_pause_resume");
        end
        $finish;
    end

endmodule
